// ===== sv/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// Types and constants shared by the detector pixel projection pipeline.
// ----------------------------------------------------------------------------
package dpp_pkg;

	localparam int POS_W   = 32;            // integer position coordinate
	localparam int COEF_W  = 32;            // Q16.16 coefficient
	localparam int OFF_W   = 48;            // Q32.16 offset
	localparam int CFG_W   = 48;            // widest register
	localparam int CIDX_W  = 3;             // register index
	localparam int FRAC_W  = 16;            // fraction bits of the coordinates
	localparam int PROD_W  = POS_W + COEF_W;        // exact product
	localparam int PAIR_W  = PROD_W + 1;            // sum of two terms
	localparam int SUM_W   = PROD_W + 2;            // sum of four terms
	localparam int COORD_W = SUM_W - FRAC_W;        // floor(sum / 2^16)
	localparam int BIN_W   = 12;            // index bits for grids up to 4096
	localparam int LIN_W   = 2 * BIN_W;     // col + COLUMNS*row, exact
	localparam int INDEX_W = 20;
	localparam int PIX_W   = 10;

	typedef enum logic [CIDX_W-1:0] {
		REG_COL_COEF_X = 3'd0,
		REG_COL_COEF_Y = 3'd1,
		REG_COL_COEF_Z = 3'd2,
		REG_ROW_COEF_X = 3'd3,
		REG_ROW_COEF_Y = 3'd4,
		REG_ROW_COEF_Z = 3'd5,
		REG_COL_OFFSET = 3'd6,
		REG_ROW_OFFSET = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0] col_x;
		logic [COEF_W-1:0] col_y;
		logic [COEF_W-1:0] col_z;
		logic [COEF_W-1:0] row_x;
		logic [COEF_W-1:0] row_y;
		logic [COEF_W-1:0] row_z;
		logic [OFF_W-1:0]  col_off;
		logic [OFF_W-1:0]  row_off;
	} coef_t;

	typedef struct packed {
		logic [PROD_W-1:0] cx;
		logic [PROD_W-1:0] cy;
		logic [PROD_W-1:0] cz;
		logic [PROD_W-1:0] rx;
		logic [PROD_W-1:0] ry;
		logic [PROD_W-1:0] rz;
	} prod_t;

endpackage

// ===== sv/dpp_mult.sv =====
// ----------------------------------------------------------------------------
// dpp_mult
// Stage 1: six signed 32x32 products of coefficients and position.
// ----------------------------------------------------------------------------
module dpp_mult (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dpp_pkg::POS_W-1:0]   pos_x,
	input  logic [dpp_pkg::POS_W-1:0]   pos_y,
	input  logic [dpp_pkg::POS_W-1:0]   pos_z,
	input  dpp_pkg::coef_t              coef,
	output logic                        prod_valid,
	input  logic                        prod_ready,
	output dpp_pkg::prod_t              prod
);

	logic           valid_s1;
	dpp_pkg::prod_t prod_s1;

	assign in_ready   = !valid_s1 || prod_ready;
	assign prod_valid = valid_s1;
	assign prod       = prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// operands sign-extend to the 64-bit result width
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1.cx <= $signed(coef.col_x) * $signed(pos_x);
			prod_s1.cy <= $signed(coef.col_y) * $signed(pos_y);
			prod_s1.cz <= $signed(coef.col_z) * $signed(pos_z);
			prod_s1.rx <= $signed(coef.row_x) * $signed(pos_x);
			prod_s1.ry <= $signed(coef.row_y) * $signed(pos_y);
			prod_s1.rz <= $signed(coef.row_z) * $signed(pos_z);
		end
	end

endmodule

// ===== sv/dpp_accum.sv =====
// ----------------------------------------------------------------------------
// dpp_accum
// Stages 2 and 3: exact sum of the three products and the offset, then
// floor to integer column and row coordinates.
// ----------------------------------------------------------------------------
module dpp_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          prod_valid,
	output logic                          prod_ready,
	input  dpp_pkg::prod_t                prod,
	input  logic [dpp_pkg::OFF_W-1:0]     col_off,
	input  logic [dpp_pkg::OFF_W-1:0]     row_off,
	output logic                          coord_valid,
	input  logic                          coord_ready,
	output logic [dpp_pkg::COORD_W-1:0]   col,
	output logic [dpp_pkg::COORD_W-1:0]   row
);

	logic                                valid_s2;
	logic                                valid_s3;
	logic                                ready_s3;
	logic signed [dpp_pkg::PAIR_W-1:0]   col_a_s2;
	logic signed [dpp_pkg::PAIR_W-1:0]   col_b_s2;
	logic signed [dpp_pkg::PAIR_W-1:0]   row_a_s2;
	logic signed [dpp_pkg::PAIR_W-1:0]   row_b_s2;
	logic signed [dpp_pkg::SUM_W-1:0]    col_sum;
	logic signed [dpp_pkg::SUM_W-1:0]    row_sum;
	logic [dpp_pkg::COORD_W-1:0]         col_s3;
	logic [dpp_pkg::COORD_W-1:0]         row_s3;

	assign prod_ready  = !valid_s2 || ready_s3;
	assign ready_s3    = !valid_s3 || coord_ready;
	assign coord_valid = valid_s3;
	assign col         = col_s3;
	assign row         = row_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (prod_ready) begin
				valid_s2 <= prod_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_valid && prod_ready) begin
			col_a_s2 <= $signed(prod.cx) + $signed(prod.cy);
			col_b_s2 <= $signed(prod.cz) + $signed(col_off);
			row_a_s2 <= $signed(prod.rx) + $signed(prod.ry);
			row_b_s2 <= $signed(prod.rz) + $signed(row_off);
		end
	end

	assign col_sum = col_a_s2 + col_b_s2;
	assign row_sum = row_a_s2 + row_b_s2;

	// dropping the fraction bits of a two's complement sum is floor()
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			col_s3 <= col_sum[dpp_pkg::SUM_W-1:dpp_pkg::FRAC_W];
			row_s3 <= row_sum[dpp_pkg::SUM_W-1:dpp_pkg::FRAC_W];
		end
	end

endmodule

// ===== sv/dpp_bin.sv =====
// ----------------------------------------------------------------------------
// dpp_bin
// Stage 4: grid range check and linear pixel index; output register.
// ----------------------------------------------------------------------------
module dpp_bin #(
	parameter int COLUMNS = 1024,
	parameter int ROWS    = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          coord_valid,
	output logic                          coord_ready,
	input  logic [dpp_pkg::COORD_W-1:0]   col,
	input  logic [dpp_pkg::COORD_W-1:0]   row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          on_detector,
	output logic [dpp_pkg::INDEX_W-1:0]   pixel_index,
	output logic [dpp_pkg::PIX_W-1:0]     pixel_column,
	output logic [dpp_pkg::PIX_W-1:0]     pixel_row
);

	logic                          valid_s4;
	logic                          on_s4;
	logic [dpp_pkg::INDEX_W-1:0]   index_s4;
	logic [dpp_pkg::PIX_W-1:0]     column_s4;
	logic [dpp_pkg::PIX_W-1:0]     row_s4;
	logic                          on_grid;
	logic [dpp_pkg::LIN_W-1:0]     linear;

	assign coord_ready  = !valid_s4 || out_ready;
	assign out_valid    = valid_s4;
	assign on_detector  = on_s4;
	assign pixel_index  = index_s4;
	assign pixel_column = column_s4;
	assign pixel_row    = row_s4;

	assign on_grid = !col[dpp_pkg::COORD_W-1] && (col < dpp_pkg::COORD_W'(COLUMNS)) &&
	                 !row[dpp_pkg::COORD_W-1] && (row < dpp_pkg::COORD_W'(ROWS));

	// constant multiplier; both indices fit in BIN_W bits when on the grid
	assign linear = dpp_pkg::LIN_W'(col[dpp_pkg::BIN_W-1:0]) +
	                dpp_pkg::LIN_W'(COLUMNS) * dpp_pkg::LIN_W'(row[dpp_pkg::BIN_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (coord_ready) begin
			valid_s4 <= coord_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coord_valid && coord_ready) begin
			on_s4 <= on_grid;
			if (on_grid) begin
				index_s4  <= linear[dpp_pkg::INDEX_W-1:0];
				column_s4 <= col[dpp_pkg::PIX_W-1:0];
				row_s4    <= row[dpp_pkg::PIX_W-1:0];
			end else begin
				index_s4  <= '0;
				column_s4 <= '0;
				row_s4    <= '0;
			end
		end
	end

endmodule

// ===== sv/detector_pixel_projection_core.sv =====
// ----------------------------------------------------------------------------
// detector_pixel_projection_core
// Orthographic projection of a 3D position onto a pixel grid.
// ----------------------------------------------------------------------------
// Takes one position per clock while the output is not stalled, and returns
// one result per position, in order. The four register stages are: six 32x32
// multipliers; pairwise sums of products and offset; final 66-bit add
// with floor to integer column/row; range check and linear index
// (col + COLUMNS*row) into the output register. Each stage holds its own
// valid bit, so bubbles collapse while the output is stalled. The projection
// registers are written through the cfg port and must only change while no
// transaction is in flight.
module detector_pixel_projection_core #(
	parameter int COLUMNS = 1024,
	parameter int ROWS    = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dpp_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [dpp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dpp_pkg::POS_W-1:0]     pos_x,
	input  logic [dpp_pkg::POS_W-1:0]     pos_y,
	input  logic [dpp_pkg::POS_W-1:0]     pos_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          on_detector,
	output logic [dpp_pkg::INDEX_W-1:0]   pixel_index,
	output logic [dpp_pkg::PIX_W-1:0]     pixel_column,
	output logic [dpp_pkg::PIX_W-1:0]     pixel_row
);

	dpp_pkg::coef_t                coef_q;
	dpp_pkg::prod_t                prod;
	logic                          prod_valid;
	logic                          prod_ready;
	logic                          coord_valid;
	logic                          coord_ready;
	logic [dpp_pkg::COORD_W-1:0]   col;
	logic [dpp_pkg::COORD_W-1:0]   row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (dpp_pkg::cfg_reg_t'(cfg_index))
				dpp_pkg::REG_COL_COEF_X: coef_q.col_x   <= cfg_data[dpp_pkg::COEF_W-1:0];
				dpp_pkg::REG_COL_COEF_Y: coef_q.col_y   <= cfg_data[dpp_pkg::COEF_W-1:0];
				dpp_pkg::REG_COL_COEF_Z: coef_q.col_z   <= cfg_data[dpp_pkg::COEF_W-1:0];
				dpp_pkg::REG_ROW_COEF_X: coef_q.row_x   <= cfg_data[dpp_pkg::COEF_W-1:0];
				dpp_pkg::REG_ROW_COEF_Y: coef_q.row_y   <= cfg_data[dpp_pkg::COEF_W-1:0];
				dpp_pkg::REG_ROW_COEF_Z: coef_q.row_z   <= cfg_data[dpp_pkg::COEF_W-1:0];
				dpp_pkg::REG_COL_OFFSET: coef_q.col_off <= cfg_data[dpp_pkg::OFF_W-1:0];
				dpp_pkg::REG_ROW_OFFSET: coef_q.row_off <= cfg_data[dpp_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	dpp_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.coef       (coef_q),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod)
	);

	dpp_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.prod_valid  (prod_valid),
		.prod_ready  (prod_ready),
		.prod        (prod),
		.col_off     (coef_q.col_off),
		.row_off     (coef_q.row_off),
		.coord_valid (coord_valid),
		.coord_ready (coord_ready),
		.col         (col),
		.row         (row)
	);

	dpp_bin #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_bin (
		.clk          (clk),
		.arst_n       (arst_n),
		.coord_valid  (coord_valid),
		.coord_ready  (coord_ready),
		.col          (col),
		.row          (row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.on_detector  (on_detector),
		.pixel_index  (pixel_index),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row)
	);

endmodule

// ===== sv/dpp_checker.sv =====
// ----------------------------------------------------------------------------
// dpp_checker
// Port-level checks for the detector pixel projection core.
// ----------------------------------------------------------------------------
module dpp_checker #(
	parameter int COLUMNS = 1024
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          on_detector,
	input logic [dpp_pkg::INDEX_W-1:0]   pixel_index,
	input logic [dpp_pkg::PIX_W-1:0]     pixel_column,
	input logic [dpp_pkg::PIX_W-1:0]     pixel_row
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(on_detector) &&
		$stable(pixel_index) && $stable(pixel_column) && $stable(pixel_row))
		else $error("result changed while stalled");

	// input backpressure only when every stage is full and the output is stalled
	a_bp_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !on_detector |-> pixel_index == '0 && pixel_column == '0 &&
		pixel_row == '0)
		else $error("off-grid result with nonzero pixel fields");

	// with a 1024-wide grid the linear index splits into row and column
	a_index_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_detector && COLUMNS == 1024 |->
		pixel_index[9:0] == pixel_column && pixel_index[19:10] == pixel_row)
		else $error("linear index disagrees with column and row");

endmodule

bind detector_pixel_projection_core dpp_checker #(
	.COLUMNS (COLUMNS)
) u_dpp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.on_detector  (on_detector),
	.pixel_index  (pixel_index),
	.pixel_column (pixel_column),
	.pixel_row    (pixel_row)
);

// ===== sim/detector_pixel_projection_core_tb.sv =====
// ----------------------------------------------------------------------------
// detector_pixel_projection_core_tb
// Self-checking bench for the pixel projection core. Positions are streamed
// through the input channel under several projection settings. Each accepted
// position is projected by an exact wide-integer model and queued, and every
// result leaving the core is compared in order against that queue.
// ----------------------------------------------------------------------------
module detector_pixel_projection_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS = 1024;
	localparam int ROWS    = 1024;
	localparam int PHASES  = 10;
	localparam int PHASE_ITEMS = 125;

	typedef struct packed {
		logic                        on;
		logic [dpp_pkg::INDEX_W-1:0] lin;
		logic [dpp_pkg::PIX_W-1:0]   col;
		logic [dpp_pkg::PIX_W-1:0]   row;
	} pixel_hit_t;

	class pixel_ledger;
		logic signed [79:0] cc_x, cc_y, cc_z, rc_x, rc_y, rc_z, c_off, r_off;
		pixel_hit_t pending_hits[$];
		int fails;

		function new;
			cc_x = '0; cc_y = '0; cc_z = '0;
			rc_x = '0; rc_y = '0; rc_z = '0;
			c_off = '0; r_off = '0;
			fails = 0;
		endfunction

		function void set_reg(dpp_pkg::cfg_reg_t r, logic [dpp_pkg::CFG_W-1:0] d);
			logic signed [dpp_pkg::COEF_W-1:0] c32;
			logic signed [dpp_pkg::OFF_W-1:0]  c48;
			c32 = d[dpp_pkg::COEF_W-1:0];
			c48 = d[dpp_pkg::OFF_W-1:0];
			case (r)
				dpp_pkg::REG_COL_COEF_X: cc_x = c32;
				dpp_pkg::REG_COL_COEF_Y: cc_y = c32;
				dpp_pkg::REG_COL_COEF_Z: cc_z = c32;
				dpp_pkg::REG_ROW_COEF_X: rc_x = c32;
				dpp_pkg::REG_ROW_COEF_Y: rc_y = c32;
				dpp_pkg::REG_ROW_COEF_Z: rc_z = c32;
				dpp_pkg::REG_COL_OFFSET: c_off = c48;
				dpp_pkg::REG_ROW_OFFSET: r_off = c48;
				default: ;
			endcase
		endfunction

		// exact Q.16 sums, then floor by arithmetic shift
		function pixel_hit_t project(logic signed [dpp_pkg::POS_W-1:0] x, y, z);
			logic signed [79:0] wx, wy, wz, colq, rowq, colf, rowf, lin;
			pixel_hit_t h;
			wx = x;
			wy = y;
			wz = z;
			colq = cc_x * wx + cc_y * wy + cc_z * wz + c_off;
			rowq = rc_x * wx + rc_y * wy + rc_z * wz + r_off;
			colf = colq >>> dpp_pkg::FRAC_W;
			rowf = rowq >>> dpp_pkg::FRAC_W;
			h = '0;
			if (colf >= 0 && colf < COLUMNS && rowf >= 0 && rowf < ROWS) begin
				lin = colf + COLUMNS * rowf;
				h.on = 1'b1;
				h.lin = lin[dpp_pkg::INDEX_W-1:0];
				h.col = colf[dpp_pkg::PIX_W-1:0];
				h.row = rowf[dpp_pkg::PIX_W-1:0];
			end
			return h;
		endfunction

		function void note_position(logic [dpp_pkg::POS_W-1:0] x, y, z);
			pending_hits.push_back(project(x, y, z));
		endfunction

		function void check_result(pixel_hit_t got);
			pixel_hit_t want;
			if (pending_hits.size() == 0) begin
				if (fails < 10)
					$display("%0t: result with nothing pending: on=%0d idx=%0d col=%0d row=%0d",
						$realtime, got.on, got.lin, got.col, got.row);
				fails++;
			end else begin
				want = pending_hits.pop_front();
				if (got.on !== want.on || got.lin !== want.lin ||
						got.col !== want.col || got.row !== want.row) begin
					if (fails < 10)
						$display({"%0t: mismatch exp on=%0d idx=%0d col=%0d row=%0d,",
							" got on=%0d idx=%0d col=%0d row=%0d"},
							$realtime, want.on, want.lin, want.col, want.row,
							got.on, got.lin, got.col, got.row);
					fails++;
				end
			end
		endfunction

		function int pending();
			return pending_hits.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [dpp_pkg::CIDX_W-1:0]    cfg_index;
	logic [dpp_pkg::CFG_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [dpp_pkg::POS_W-1:0]     pos_x, pos_y, pos_z;
	logic                          out_valid;
	logic                          out_ready;
	logic                          on_detector;
	logic [dpp_pkg::INDEX_W-1:0]   pixel_index;
	logic [dpp_pkg::PIX_W-1:0]     pixel_column;
	logic [dpp_pkg::PIX_W-1:0]     pixel_row;

	pixel_ledger ledger;
	int src_idle_pct;
	int sink_idle_pct;

	detector_pixel_projection_core #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.on_detector(on_detector),
		.pixel_index(pixel_index),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_result({on_detector, pixel_index, pixel_column, pixel_row});
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_pos(logic [dpp_pkg::POS_W-1:0] px, py, pz);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do
			@(posedge clk);
		while (!in_ready);
		ledger.note_position(px, py, pz);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(dpp_pkg::cfg_reg_t r, logic [dpp_pkg::CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		ledger.set_reg(r, d);
		@(negedge clk);
	endtask

	// upper bits of coefficient writes carry junk the core must ignore
	task automatic program_regs(dpp_pkg::coef_t c);
		write_reg(dpp_pkg::REG_COL_COEF_X, {16'($urandom), c.col_x});
		write_reg(dpp_pkg::REG_COL_COEF_Y, {16'($urandom), c.col_y});
		write_reg(dpp_pkg::REG_COL_COEF_Z, {16'($urandom), c.col_z});
		write_reg(dpp_pkg::REG_ROW_COEF_X, {16'($urandom), c.row_x});
		write_reg(dpp_pkg::REG_ROW_COEF_Y, {16'($urandom), c.row_y});
		write_reg(dpp_pkg::REG_ROW_COEF_Z, {16'($urandom), c.row_z});
		write_reg(dpp_pkg::REG_COL_OFFSET, c.col_off);
		write_reg(dpp_pkg::REG_ROW_OFFSET, c.row_off);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [dpp_pkg::COEF_W-1:0] near_unit_coef();
		return dpp_pkg::COEF_W'(int'($urandom_range(1 << 18)) - (1 << 17));
	endfunction

	function automatic logic [dpp_pkg::OFF_W-1:0] grid_offset();
		int base;
		base = int'($urandom_range(512)) + 256;
		return {32'(base), 16'($urandom)};
	endfunction

	// wild settings use full-range values and rarely land on the grid
	function automatic dpp_pkg::coef_t random_setting(bit wild);
		dpp_pkg::coef_t c;
		if (wild) begin
			c.col_x = $urandom;
			c.col_y = $urandom;
			c.col_z = $urandom;
			c.row_x = $urandom;
			c.row_y = $urandom;
			c.row_z = $urandom;
			c.col_off = {16'($urandom), $urandom};
			c.row_off = {16'($urandom), $urandom};
		end else begin
			c.col_x = near_unit_coef();
			c.col_y = near_unit_coef();
			c.col_z = near_unit_coef();
			c.row_x = near_unit_coef();
			c.row_y = near_unit_coef();
			c.row_z = near_unit_coef();
			c.col_off = grid_offset();
			c.row_off = grid_offset();
		end
		return c;
	endfunction

	function automatic logic [dpp_pkg::POS_W-1:0] random_coord();
		if ($urandom_range(99) < 80)
			return dpp_pkg::POS_W'(int'($urandom_range(1400)) - 700);
		return $urandom;
	endfunction

	task automatic set_idle(int phase);
		if (phase < 4) begin
			src_idle_pct = 15;
			sink_idle_pct = 83;
		end else if (phase < 7) begin
			src_idle_pct = 83;
			sink_idle_pct = 15;
		end else begin
			src_idle_pct = 0;
			sink_idle_pct = 0;
		end
	endtask

	initial begin
		#5_000_000;
		$display("detector_pixel_projection_core regression: fail");
		$finish;
	end

	initial begin
		dpp_pkg::coef_t c;
		ledger = new;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dpp_pkg::REG_COL_COEF_X;
		cfg_data = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		set_idle(0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: every point projects to pixel zero
		send_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pos(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);
		drain();

		// col = x + z/2, row = y: grid edges and floor of negative fractions
		c = '0;
		c.col_x = 32'h0001_0000;
		c.col_z = 32'h0000_8000;
		c.row_y = 32'h0001_0000;
		program_regs(c);
		send_pos(32'd0, 32'd0, 32'd0);
		send_pos(32'd1023, 32'd1023, 32'd0);
		send_pos(32'd1024, 32'd0, 32'd0);
		send_pos(32'hffff_ffff, 32'd0, 32'd0);
		send_pos(32'd0, 32'd1024, 32'd0);
		send_pos(32'd0, 32'hffff_ffff, 32'd0);
		send_pos(32'd0, 32'd0, 32'hffff_ffff);
		send_pos(32'd1, 32'd0, 32'hffff_ffff);
		send_pos(32'd5, 32'd7, 32'd3);
		drain();

		// extreme operands, sums must not wrap
		c.col_x = 32'h8000_0000;
		c.col_y = 32'h8000_0000;
		c.col_z = 32'h8000_0000;
		c.row_x = 32'h8000_0000;
		c.row_y = 32'h8000_0000;
		c.row_z = 32'h8000_0000;
		c.col_off = 48'h7fff_ffff_ffff;
		c.row_off = 48'h7fff_ffff_ffff;
		program_regs(c);
		send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pos(32'd0, 32'd0, 32'd0);
		drain();

		c.col_x = 32'h7fff_ffff;
		c.col_y = 32'h7fff_ffff;
		c.col_z = 32'h7fff_ffff;
		c.row_x = 32'h7fff_ffff;
		c.row_y = 32'h7fff_ffff;
		c.row_z = 32'h7fff_ffff;
		c.col_off = 48'h8000_0000_0000;
		c.row_off = 48'h8000_0000_0000;
		program_regs(c);
		send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pos(32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			set_idle(phase);
			program_regs(random_setting(phase % 4 == 3));
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pos(random_coord(), random_coord(), random_coord());
			drain();
		end

		if (ledger.fails == 0)
			$display("detector_pixel_projection_core regression: pass");
		else
			$display("detector_pixel_projection_core regression: fail");
		$finish;
	end

endmodule

// ===== detector_pixel_projection_core.f =====
sv/dpp_pkg.sv
sv/dpp_mult.sv
sv/dpp_accum.sv
sv/dpp_bin.sv
sv/detector_pixel_projection_core.sv
sv/dpp_checker.sv
sim/detector_pixel_projection_core_tb.sv
